// ===== hw/rtl/djct_pkg.sv =====
`timescale 1ns / 1ps
package djct_pkg;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_WAIT   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_PAST    = 3'd1,
    ST_WAITING = 3'd2,
    ST_MISSING = 3'd3,
    ST_EXISTS  = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_APPLY
  } state_t;

  localparam logic signed [16:0] COUNT_MAX = 17'sd32767;

  typedef struct packed {
    op_t                op;
    logic [31:0]        deadline;
    logic signed [15:0] increment;
  } item_t;

  typedef struct packed {
    status_t status;
    logic    wake;
    logic    underflow;
  } result_t;

  // search token that walks the row of cells, one cell per cycle
  typedef struct packed {
    logic               live;
    logic [31:0]        key;
    logic               match;
    logic signed [15:0] count;
    logic               waiter;
    logic               free_found;
    logic               any_valid;
    logic [31:0]        min_dl;
  } tok_t;

  // write broadcast to the cell that claimed the match or the free slot
  typedef struct packed {
    logic               en;
    logic               to_match;
    logic               valid;
    logic               waiter;
    logic signed [15:0] count;
    logic [31:0]        deadline;
  } wr_t;

endpackage

// ===== hw/rtl/deadline_job_count_table.sv =====
`timescale 1ns / 1ps
// channel   ports                         beat taken when
// item      start, busy, item             start high and busy low
// result    done, result                  done high (one cycle, no back-pressure)
//
// one item at a time: a new item is accepted only after the previous result is out
// the search token steps through the row of ENTRIES cells one cell a cycle;
// the result shows in the cycle after the token leaves the last cell, while the
// claimed entry is written back
// synchronous reset empties the table; no clearing pass is needed
// results cannot be held off, so busy depends only on the item in flight
module deadline_job_count_table #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  djct_pkg::item_t   item,
  output logic              busy,
  output djct_pkg::result_t result,
  output logic              done
);

  djct_pkg::tok_t chain [ENTRIES+1];
  djct_pkg::wr_t  wr;
  logic           clr;

  djct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .tail   (chain[ENTRIES]),
    .busy   (busy),
    .clr    (clr),
    .head   (chain[0]),
    .wr     (wr),
    .result (result),
    .done   (done)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    djct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clr),
      .tok_in  (chain[i]),
      .wr      (wr),
      .tok_out (chain[i+1])
    );
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && !chain[ENTRIES].live)
    else $error("result while idle or token still in row");

  a_flags_update: assert property (@(posedge clk) disable iff (rst)
    done && (result.wake || result.underflow) |-> result.status == djct_pkg::ST_UPDATED)
    else $error("wake or underflow on a non-update status");

  a_write_on_done: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> done)
    else $error("table write outside the result cycle");

endmodule

// ===== hw/rtl/djct_cell.sv =====
`timescale 1ns / 1ps
module djct_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           clr,
  input  djct_pkg::tok_t tok_in,
  input  djct_pkg::wr_t  wr,
  output djct_pkg::tok_t tok_out
);

  logic               valid;
  logic [31:0]        deadline;
  logic signed [15:0] count;
  logic               waiter;
  logic               sel_match;
  logic               sel_free;

  logic               hit;
  logic               first_hit;
  logic               first_free;
  djct_pkg::tok_t     tok_next;

  assign hit        = valid && (deadline == tok_in.key);
  assign first_hit  = hit && !tok_in.match;
  assign first_free = !valid && !tok_in.free_found;

  always_comb begin
    tok_next            = tok_in;
    tok_next.match      = tok_in.match | hit;
    tok_next.free_found = tok_in.free_found | !valid;
    tok_next.any_valid  = tok_in.any_valid | valid;
    if (first_hit) begin
      tok_next.count  = count;
      tok_next.waiter = waiter;
    end
    // running minimum over the occupied entries
    if (valid && (!tok_in.any_valid || deadline < tok_in.min_dl)) begin
      tok_next.min_dl = deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_match <= 1'b0;
      sel_free  <= 1'b0;
    end else if (clr) begin
      sel_match <= 1'b0;
      sel_free  <= 1'b0;
    end else if (tok_in.live) begin
      if (first_hit) begin
        sel_match <= 1'b1;
      end
      if (first_free) begin
        sel_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && ((wr.to_match && sel_match) || (!wr.to_match && sel_free))) begin
      valid <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && ((wr.to_match && sel_match) || (!wr.to_match && sel_free))) begin
      deadline <= wr.deadline;
      count    <= wr.count;
      waiter   <= wr.waiter;
    end
  end

endmodule

// ===== hw/rtl/djct_ctrl.sv =====
`timescale 1ns / 1ps
module djct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  djct_pkg::item_t   item,
  input  djct_pkg::tok_t    tail,
  output logic              busy,
  output logic              clr,
  output djct_pkg::tok_t    head,
  output djct_pkg::wr_t     wr,
  output djct_pkg::result_t result,
  output logic              done
);

  djct_pkg::state_t   state;
  djct_pkg::state_t   state_next;
  djct_pkg::item_t    item_q;
  djct_pkg::result_t  result_next;
  djct_pkg::wr_t      wr_next;
  logic               accept;
  logic               finish;
  logic               have_slot;
  logic               inc_pos;
  logic signed [15:0] base_count;
  logic signed [16:0] sum;
  logic signed [15:0] sum_sat;

  assign accept = start && !busy;
  assign finish = (state == djct_pkg::S_SWEEP) && tail.live;

  always_comb begin
    state_next = state;
    unique case (state)
      djct_pkg::S_IDLE:  if (start) state_next = djct_pkg::S_SWEEP;
      djct_pkg::S_SWEEP: if (tail.live) state_next = djct_pkg::S_APPLY;
      djct_pkg::S_APPLY: state_next = djct_pkg::S_IDLE;
      default:           state_next = djct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    clr  = 1'b0;
    done = 1'b0;
    unique case (state)
      djct_pkg::S_IDLE: begin
        busy = 1'b0;
        clr  = start;
      end
      djct_pkg::S_SWEEP: begin
      end
      djct_pkg::S_APPLY: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= djct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.live <= 1'b0;
    end else if (accept) begin
      head.live       <= 1'b1;
      head.key        <= item.deadline;
      head.match      <= 1'b0;
      head.count      <= '0;
      head.waiter     <= 1'b0;
      head.free_found <= 1'b0;
      head.any_valid  <= 1'b0;
      head.min_dl     <= '0;
    end else begin
      head.live <= 1'b0;
    end
  end

  // read-modify-write of the claimed entry once the token leaves the row
  assign inc_pos    = !item_q.increment[15] && (item_q.increment != 16'sd0);
  assign base_count = tail.match ? tail.count : 16'sd0;
  assign sum        = {base_count[15], base_count} + {item_q.increment[15], item_q.increment};
  assign sum_sat    = (sum > djct_pkg::COUNT_MAX) ? 16'sh7fff : sum[15:0];

  always_comb begin
    result_next.status    = djct_pkg::ST_UPDATED;
    result_next.wake      = 1'b0;
    result_next.underflow = 1'b0;
    wr_next               = '0;
    have_slot             = 1'b0;
    if (item_q.op == djct_pkg::OP_UPDATE) begin
      priority if (tail.match) begin
        have_slot = 1'b1;
      end else if (!inc_pos) begin
        result_next.underflow = item_q.increment[15];
      end else if (!tail.free_found) begin
        result_next.status = djct_pkg::ST_FULL;
      end else begin
        have_slot = 1'b1;
      end
      if (have_slot) begin
        wr_next.en       = 1'b1;
        wr_next.to_match = tail.match;
        wr_next.deadline = item_q.deadline;
        if (sum_sat[15] || sum_sat == 16'sd0) begin
          // count exhausted: free the entry
          result_next.wake      = tail.match && tail.waiter;
          result_next.underflow = sum_sat[15];
          wr_next.valid         = 1'b0;
          wr_next.waiter        = 1'b0;
          wr_next.count         = 16'sd0;
        end else begin
          wr_next.valid  = 1'b1;
          wr_next.waiter = tail.match && tail.waiter;
          wr_next.count  = sum_sat;
        end
      end
    end else begin
      priority if (tail.match) begin
        if (tail.waiter) begin
          result_next.status = djct_pkg::ST_EXISTS;
        end else begin
          result_next.status = djct_pkg::ST_WAITING;
          wr_next.en         = 1'b1;
          wr_next.to_match   = 1'b1;
          wr_next.valid      = 1'b1;
          wr_next.waiter     = 1'b1;
          wr_next.count      = tail.count;
          wr_next.deadline   = item_q.deadline;
        end
      end else if (tail.any_valid && item_q.deadline < tail.min_dl) begin
        result_next.status = djct_pkg::ST_PAST;
      end else begin
        result_next.status = djct_pkg::ST_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr.en <= 1'b0;
    end else if (finish) begin
      wr <= wr_next;
    end else begin
      wr.en <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= result_next;
    end
  end

endmodule
